// ===== src/htm_pkg.sv =====
// Shared constants and types for the RGBE tone-map pixel pipeline.
`default_nettype none

package htm_pkg;

  localparam int GAMMA_TABLE_BITS_DEF = 10;
  localparam int LINEAR_FRAC_BITS_DEF = 16;

  // RGBE exponent bias: scale is 2^(e - 136)
  localparam int EXPO_BIAS = 136;

  // 0.6 in Q16
  localparam logic [15:0] K_SCALE06 = 16'd39322;
  // filmic curve coefficients in Q16
  localparam logic [17:0] K_A = 18'd164495;
  localparam logic [10:0] K_B = 11'd1966;
  localparam logic [17:0] K_C = 18'd159252;
  localparam logic [15:0] K_D = 16'd38666;
  localparam logic [13:0] K_E = 14'd9175;

  // luma weights, sum is 256
  localparam logic [7:0] W_R = 8'd77;
  localparam logic [7:0] W_G = 8'd150;
  localparam logic [7:0] W_B = 8'd29;

  localparam logic [15:0] ADJ_MAX  = 16'd65280;
  localparam logic [7:0]  CHAN_MAX = 8'd255;

  localparam int CHAN_LAT  = 22;
  localparam int LEVEL_LAT = 28;
  localparam int BACK_LAT  = CHAN_LAT + LEVEL_LAT;

  localparam int FIFO_DEPTH = 4;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;
  localparam logic [CFG_IDX_W-1:0] REG_EXPOSURE_GAIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLACK_LEVEL   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WHITE_LEVEL   = 2'd2;

  localparam logic [23:0] EXPOSURE_RESET = 24'd65536;
  localparam logic [7:0]  BLACK_RESET    = 8'd0;
  localparam logic [7:0]  WHITE_RESET    = 8'd255;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

`default_nettype wire

// ===== src/htm_if.sv =====
// Channel interfaces: RGBE pixel in, tone-mapped pixel out, register writes.
`default_nettype none

interface htm_pix_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] mantissa_red;
  logic [7:0] mantissa_green;
  logic [7:0] mantissa_blue;
  logic [7:0] shared_exponent;
  logic       last_pixel;

  modport source (output valid, mantissa_red, mantissa_green, mantissa_blue,
                  shared_exponent, last_pixel, input ready);
  modport sink   (input valid, mantissa_red, mantissa_green, mantissa_blue,
                  shared_exponent, last_pixel, output ready);
endinterface

interface htm_pix_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] intensity_bin;
  logic [7:0] adjusted_bin;
  logic       frame_end;

  modport source (output valid, red, green, blue, intensity_bin, adjusted_bin,
                  frame_end, input ready);
  modport sink   (input valid, red, green, blue, intensity_bin, adjusted_bin,
                  frame_end, output ready);
endinterface

interface htm_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [htm_pkg::CFG_IDX_W-1:0]   reg_index;
  logic [htm_pkg::CFG_DATA_W-1:0]  wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink   (input valid, reg_index, wdata, output ready);
endinterface

`default_nettype wire

// ===== src/htm_front.sv =====
// Front end: accepts RGBE pixels and decodes each mantissa to linear fixed point.
`default_nettype none

module htm_front #(
  parameter int LINEAR_FRAC_BITS = htm_pkg::LINEAR_FRAC_BITS_DEF
) (
  htm_pix_in_if.sink                         pix_i,
  input  htm_pkg::fifo_stat_t                stat_i,
  output logic                               push_o,
  output logic [3*(16+LINEAR_FRAC_BITS):0]   entry_o
);

  localparam int LinW  = 16 + LINEAR_FRAC_BITS;
  localparam int WideW = LinW + 8;

  // mant * 2^(expo-136+F), saturating high, truncating low
  function automatic logic [LinW-1:0] decode(logic [7:0] mant, logic [7:0] expo);
    logic [8:0]       ebias;
    logic [8:0]       sh;
    logic [WideW-1:0] wide;
    logic [LinW-1:0]  res;
    ebias = 9'(expo) + 9'(LINEAR_FRAC_BITS);
    res   = '0;
    wide  = '0;
    if (ebias >= 9'(htm_pkg::EXPO_BIAS)) begin
      sh = ebias - 9'(htm_pkg::EXPO_BIAS);
      if (mant == 8'd0) begin
        res = '0;
      end else if (sh >= 9'(LinW)) begin
        res = '1;
      end else begin
        wide = WideW'(mant) << sh;
        res  = (wide[WideW-1:LinW] != '0) ? '1 : wide[LinW-1:0];
      end
    end else begin
      sh = 9'(htm_pkg::EXPO_BIAS) - ebias;
      if (sh < 9'd8) begin
        res = LinW'(mant >> sh);
      end
    end
    return res;
  endfunction

  assign pix_i.ready = !stat_i.full;
  assign push_o      = pix_i.valid && !stat_i.full;

  assign entry_o = {pix_i.last_pixel,
                    decode(pix_i.mantissa_blue,  pix_i.shared_exponent),
                    decode(pix_i.mantissa_green, pix_i.shared_exponent),
                    decode(pix_i.mantissa_red,   pix_i.shared_exponent)};

endmodule

`default_nettype wire

// ===== src/htm_fifo.sv =====
// Short queue between the decode front end and the tone-map back end.
`default_nettype none

module htm_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = htm_pkg::FIFO_DEPTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  logic [WIDTH-1:0]    wdata_i,
  input  logic                pop_i,
  output logic [WIDTH-1:0]    rdata_o,
  output htm_pkg::fifo_stat_t stat_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  count_q;

  assign stat_o.full  = (count_q == CntW'(DEPTH));
  assign stat_o.empty = (count_q == '0);
  assign rdata_o      = mem[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (!push_i && pop_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/htm_chan.sv =====
// One color channel: exposure, filmic curve with pipelined divide, gamma ROM.
`default_nettype none

module htm_chan #(
  parameter int GAMMA_TABLE_BITS = htm_pkg::GAMMA_TABLE_BITS_DEF,
  parameter int LINEAR_FRAC_BITS = htm_pkg::LINEAR_FRAC_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            adv_i,
  input  logic [16+LINEAR_FRAC_BITS-1:0]  lin_i,
  input  logic [23:0]                     gain_i,
  output logic [7:0]                      code_o
);

  localparam int G       = GAMMA_TABLE_BITS;
  localparam int F       = LINEAR_FRAC_BITS;
  localparam int LinW    = 16 + F;
  localparam int AddrW   = G + 1;
  localparam int RomSize = (1 << G) + 1;
  localparam int Steps   = 17;

  // entry i = floor(255 * (i/2^G)^(5/9)), exact integer search
  function automatic logic [RomSize*8-1:0] build_rom();
    logic [RomSize*8-1:0] rom;
    logic [159:0]         rhs;
    logic [159:0]         lhs;
    logic [8:0]           y;
    logic                 done;
    rom = '0;
    y   = '0;
    for (int i = 0; i < RomSize; i++) begin
      rhs = 160'd1;
      for (int k = 0; k < 5; k++) rhs = rhs * 160'(i);
      for (int k = 0; k < 9; k++) rhs = rhs * 160'd255;
      done = 1'b0;
      while (!done) begin
        if (y >= 9'd255) begin
          done = 1'b1;
        end else begin
          lhs = 160'd1;
          for (int k = 0; k < 9; k++) lhs = lhs * 160'(y + 9'd1);
          lhs = lhs << (5 * G);
          if (lhs <= rhs) y = y + 9'd1;
          else            done = 1'b1;
        end
      end
      rom[i*8 +: 8] = y[7:0];
    end
    return rom;
  endfunction

  localparam logic [RomSize*8-1:0] GammaRom = build_rom();

  // exposure product
  logic [LinW+23:0] prod_q;
  always_ff @(posedge clk_i) begin
    if (adv_i) prod_q <= lin_i * gain_i;
  end

  // saturate, scale by 0.6
  logic [LinW+7:0]  vsh;
  logic [LinW-1:0]  vsat;
  logic [LinW+15:0] xfull;
  logic [31:0]      x_q;
  always_comb begin
    vsh   = prod_q[LinW+23:16];
    vsat  = (vsh[LinW+7:LinW] != '0) ? '1 : vsh[LinW-1:0];
    xfull = vsat * htm_pkg::K_SCALE06;
  end
  always_ff @(posedge clk_i) begin
    if (adv_i) x_q <= xfull[LinW+15:F];
  end

  // inner polynomial terms; x >= 8.0 saturates the curve
  logic [18:0] xs;
  logic [36:0] pa, pc;
  logic [20:0] p_q, qd_q;
  logic [18:0] xs_q;
  logic        big3_q;
  always_comb begin
    xs = x_q[18:0];
    pa = xs * htm_pkg::K_A;
    pc = xs * htm_pkg::K_C;
  end
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      p_q    <= pa[36:16] + 21'(htm_pkg::K_B);
      qd_q   <= pc[36:16] + 21'(htm_pkg::K_D);
      xs_q   <= xs;
      big3_q <= (x_q[31:19] != '0);
    end
  end

  // numerator and denominator
  logic [39:0] nprod, dprod;
  logic [39:0] n_q;
  logic [40:0] d_q;
  logic        big4_q;
  always_comb begin
    nprod = xs_q * p_q;
    dprod = xs_q * qd_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      n_q    <= nprod;
      d_q    <= {1'b0, dprod} + (41'(htm_pkg::K_E) << 16);
      big4_q <= big3_q;
    end
  end

  // restoring divide, one quotient bit per stage: t = (n << 16) / d
  logic [41:0] r_q  [Steps];
  logic [40:0] dv_q [Steps];
  logic [16:0] qt_q [Steps];
  logic        bg_q [Steps];

  for (genvar k = 0; k < Steps; k++) begin : g_div
    logic [41:0] rin;
    logic [40:0] dv;
    logic [16:0] qin;
    logic        bg;
    logic        ge;
    if (k == 0) begin : g_first
      assign rin = {2'b00, n_q};
      assign dv  = d_q;
      assign qin = '0;
      assign bg  = big4_q;
    end else begin : g_next
      assign rin = {r_q[k-1][40:0], 1'b0};
      assign dv  = dv_q[k-1];
      assign qin = qt_q[k-1];
      assign bg  = bg_q[k-1];
    end
    assign ge = (rin >= {1'b0, dv});
    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        r_q[k]  <= ge ? rin - {1'b0, dv} : rin;
        dv_q[k] <= dv;
        qt_q[k] <= {qin[15:0], ge};
        bg_q[k] <= bg;
      end
    end
  end

  // gamma lookup, registered read
  logic [16:0]      t;
  logic [AddrW-1:0] addr;
  always_comb begin
    t = qt_q[Steps-1];
    if (bg_q[Steps-1] || t[16]) begin
      addr = {1'b1, G'(0)};
    end else begin
      addr = {1'b0, t[15:16-G]};
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv_i) code_o <= GammaRom[addr*8 +: 8];
  end

endmodule

`default_nettype wire

// ===== src/htm_level.sv =====
// Luma, black/white level stretch and per-channel rescale, pipelined divides.
`default_nettype none

module htm_level (
  input  logic            clk_i,
  input  logic            adv_i,
  input  logic [2:0][7:0] chan_i,
  input  logic [7:0]      black_i,
  input  logic [7:0]      white_i,
  output logic [2:0][7:0] chan_o,
  output logic [7:0]      ibin_o,
  output logic [7:0]      abin_o
);

  localparam int ASteps = 16;
  localparam int CSteps = 8;

  logic        ok;
  logic [7:0]  span;
  logic [15:0] lo;
  assign ok   = (white_i > black_i);
  assign span = white_i - black_i;
  assign lo   = {black_i, 8'h00};

  // luma in Q8.8
  logic [15:0]     luma0_q;
  logic [2:0][7:0] c0_q;
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      luma0_q <= 16'(chan_i[0] * htm_pkg::W_R) + 16'(chan_i[1] * htm_pkg::W_G)
               + 16'(chan_i[2] * htm_pkg::W_B);
      c0_q    <= chan_i;
    end
  end

  // adj = (luma - lo) * 255 / span, 16 quotient bits, overflow flagged up front
  logic [7:0]      ar_q   [ASteps+1];
  logic [15:0]     anum_q [ASteps+1];
  logic [15:0]     aq_q   [ASteps+1];
  logic            asat_q [ASteps+1];
  logic [15:0]     al_q   [ASteps+1];
  logic [2:0][7:0] ac_q   [ASteps+1];

  logic [15:0] diff;
  logic [23:0] num;
  always_comb begin
    diff = (luma0_q > lo) ? luma0_q - lo : '0;
    num  = {diff, 8'h00} - {8'h00, diff};
  end
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      ar_q[0]   <= num[23:16];
      anum_q[0] <= num[15:0];
      aq_q[0]   <= '0;
      asat_q[0] <= (num[23:16] >= span);
      al_q[0]   <= luma0_q;
      ac_q[0]   <= c0_q;
    end
  end

  for (genvar k = 1; k <= ASteps; k++) begin : g_adiv
    logic [8:0] rin;
    logic       ge;
    logic [8:0] rsub;
    assign rin  = {ar_q[k-1], anum_q[k-1][ASteps-k]};
    assign ge   = (rin >= {1'b0, span});
    assign rsub = rin - {1'b0, span};
    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        ar_q[k]   <= ge ? rsub[7:0] : rin[7:0];
        anum_q[k] <= anum_q[k-1];
        aq_q[k]   <= {aq_q[k-1][14:0], ge};
        asat_q[k] <= asat_q[k-1];
        al_q[k]   <= al_q[k-1];
        ac_q[k]   <= ac_q[k-1];
      end
    end
  end

  // clamp adj, start channel rescale c * adj / luma
  logic [15:0] adj;
  always_comb begin
    if (!ok) begin
      adj = '0;
    end else if (asat_q[ASteps] || aq_q[ASteps] > htm_pkg::ADJ_MAX) begin
      adj = htm_pkg::ADJ_MAX;
    end else begin
      adj = aq_q[ASteps];
    end
  end

  logic [2:0][15:0] cr_q   [CSteps+1];
  logic [2:0][7:0]  cnlo_q [CSteps+1];
  logic [2:0][7:0]  cq_q   [CSteps+1];
  logic [2:0]       csat_q [CSteps+1];
  logic [15:0]      cadj_q [CSteps+1];
  logic [15:0]      cl_q   [CSteps+1];

  for (genvar ch = 0; ch < 3; ch++) begin : g_cnum
    logic [23:0] cn;
    assign cn = 24'(ac_q[ASteps][ch]) * 24'(adj);
    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        cr_q[0][ch]   <= cn[23:8];
        cnlo_q[0][ch] <= cn[7:0];
        cq_q[0][ch]   <= '0;
        csat_q[0][ch] <= (cn[23:8] >= al_q[ASteps]);
      end
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      cadj_q[0] <= adj;
      cl_q[0]   <= al_q[ASteps];
    end
  end

  for (genvar k = 1; k <= CSteps; k++) begin : g_cdiv
    for (genvar ch = 0; ch < 3; ch++) begin : g_ch
      logic [16:0] rin;
      logic        ge;
      logic [16:0] rsub;
      assign rin  = {cr_q[k-1][ch], cnlo_q[k-1][ch][CSteps-k]};
      assign ge   = (rin >= {1'b0, cl_q[k-1]});
      assign rsub = rin - {1'b0, cl_q[k-1]};
      always_ff @(posedge clk_i) begin
        if (adv_i) begin
          cr_q[k][ch]   <= ge ? rsub[15:0] : rin[15:0];
          cnlo_q[k][ch] <= cnlo_q[k-1][ch];
          cq_q[k][ch]   <= {cq_q[k-1][ch][6:0], ge};
          csat_q[k][ch] <= csat_q[k-1][ch];
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        cadj_q[k] <= cadj_q[k-1];
        cl_q[k]   <= cl_q[k-1];
      end
    end
  end

  // output register
  for (genvar ch = 0; ch < 3; ch++) begin : g_out
    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        if (!ok || cl_q[CSteps] == '0) begin
          chan_o[ch] <= '0;
        end else if (csat_q[CSteps][ch]) begin
          chan_o[ch] <= htm_pkg::CHAN_MAX;
        end else begin
          chan_o[ch] <= cq_q[CSteps][ch];
        end
      end
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      ibin_o <= cl_q[CSteps][15:8];
      abin_o <= cadj_q[CSteps][15:8];
    end
  end

endmodule

`default_nettype wire

// ===== src/hdr_rgbe_tone_map_pixel.sv =====
// RGBE to 8-bit RGB tone mapper: filmic curve, gamma 1/1.8, black/white levels.
//
// pix_i takes one RGBE pixel per transaction (valid/ready); pix_o returns one
// RGB pixel per transaction, with the luma bins before and after the level
// stretch and frame_end copied from last_pixel. cfg_i writes exposure_gain
// (index 0), black_level (1) and white_level (2); other indexes are ignored.
// Write registers only while no pixel is in flight.
// Throughput: one pixel per clock while pix_o does not stall. The back end
// holds the 17-step curve divider, the 16-step level divider and the 8-step
// channel rescale divider, all one-bit-per-stage pipelines.
// The decode front end writes into a 4-entry queue; the back end pipeline
// advances as a whole whenever its output register is empty or being taken.
// When pix_o stalls the back pipeline freezes, the queue fills and then
// pix_i.ready drops. Reset empties queue and pipeline and loads the register
// defaults (gain 1.0, black 0, white 255).
`default_nettype none

module hdr_rgbe_tone_map_pixel #(
  parameter int GAMMA_TABLE_BITS = htm_pkg::GAMMA_TABLE_BITS_DEF,
  parameter int LINEAR_FRAC_BITS = htm_pkg::LINEAR_FRAC_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  htm_pix_in_if.sink    pix_i,
  htm_pix_out_if.source pix_o,
  htm_cfg_if.sink       cfg_i
);

  localparam int LinW   = 16 + LINEAR_FRAC_BITS;
  localparam int EntryW = 3 * LinW + 1;
  localparam int Lat    = htm_pkg::BACK_LAT;

  // configuration registers
  logic [23:0] gain_q;
  logic [7:0]  black_q, white_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q  <= htm_pkg::EXPOSURE_RESET;
      black_q <= htm_pkg::BLACK_RESET;
      white_q <= htm_pkg::WHITE_RESET;
    end else if (cfg_i.valid) begin
      case (cfg_i.reg_index)
        htm_pkg::REG_EXPOSURE_GAIN: gain_q  <= cfg_i.wdata;
        htm_pkg::REG_BLACK_LEVEL:   black_q <= cfg_i.wdata[7:0];
        htm_pkg::REG_WHITE_LEVEL:   white_q <= cfg_i.wdata[7:0];
        default: ;
      endcase
    end
  end

  // front end and queue
  htm_pkg::fifo_stat_t fifo_stat;
  logic                push;
  logic                pop;
  logic [EntryW-1:0]   entry;
  logic [EntryW-1:0]   head;

  htm_front #(
    .LINEAR_FRAC_BITS(LINEAR_FRAC_BITS)
  ) u_front (
    .pix_i   (pix_i),
    .stat_i  (fifo_stat),
    .push_o  (push),
    .entry_o (entry)
  );

  htm_fifo #(
    .WIDTH(EntryW),
    .DEPTH(htm_pkg::FIFO_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (entry),
    .pop_i   (pop),
    .rdata_o (head),
    .stat_o  (fifo_stat)
  );

  // back end: whole pipeline moves when the output slot is free or taken
  logic           adv;
  logic [Lat-1:0] vld_q;
  logic [Lat-1:0] last_q;

  assign adv = !vld_q[Lat-1] || pix_o.ready;
  assign pop = adv && !fifo_stat.empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[Lat-2:0], pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) last_q <= {last_q[Lat-2:0], head[EntryW-1]};
  end

  logic [2:0][7:0] code;

  for (genvar ch = 0; ch < 3; ch++) begin : g_chan
    htm_chan #(
      .GAMMA_TABLE_BITS(GAMMA_TABLE_BITS),
      .LINEAR_FRAC_BITS(LINEAR_FRAC_BITS)
    ) u_chan (
      .clk_i  (clk_i),
      .adv_i  (adv),
      .lin_i  (head[ch*LinW +: LinW]),
      .gain_i (gain_q),
      .code_o (code[ch])
    );
  end

  logic [2:0][7:0] chan_out;

  htm_level u_level (
    .clk_i   (clk_i),
    .adv_i   (adv),
    .chan_i  (code),
    .black_i (black_q),
    .white_i (white_q),
    .chan_o  (chan_out),
    .ibin_o  (pix_o.intensity_bin),
    .abin_o  (pix_o.adjusted_bin)
  );

  assign pix_o.valid     = vld_q[Lat-1];
  assign pix_o.red       = chan_out[0];
  assign pix_o.green     = chan_out[1];
  assign pix_o.blue      = chan_out[2];
  assign pix_o.frame_end = last_q[Lat-1];

`ifndef SYNTHESIS
  // an accepted pixel is held in the queue on the next cycle
  a_push_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_i.valid && pix_i.ready |=> !fifo_stat.empty)
    else $error("accepted pixel missing from queue");

  // a stalled back end keeps every in-flight pixel in place
  a_stall_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(vld_q))
    else $error("pipeline moved while stalled");

  // a queued pixel enters the back end whenever it advances
  a_pop_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && !fifo_stat.empty |=> vld_q[0])
    else $error("popped pixel not in first back-end stage");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/tb_hdr_rgbe_tone_map_pixel.sv =====
// Self-checking testbench for the RGBE tone-map pixel pipeline.
`timescale 1ns / 1ps

// Scoreboard: holds the register copies and the gamma table, predicts each
// tone-mapped pixel and compares it with what the block returns.
class tone_map_scoreboard;
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] intensity_bin;
    logic [7:0] adjusted_bin;
    logic       frame_end;
  } rgb_px_t;

  logic [23:0] gain;
  logic [7:0]  black;
  logic [7:0]  white;
  logic [7:0]  gamma_rom [0:1024];
  rgb_px_t     pending_px [$];
  int          errors;

  function new();
    logic [159:0] rhs;
    logic [159:0] lhs;
    int y;
    gain   = htm_pkg::EXPOSURE_RESET;
    black  = htm_pkg::BLACK_RESET;
    white  = htm_pkg::WHITE_RESET;
    errors = 0;
    y = 0;
    // entry i = floor(255*(i/1024)^(5/9)): largest y with y^9*2^50 <= i^5*255^9
    for (int i = 0; i <= 1024; i++) begin
      rhs = 160'(i) * i * i * i * i;
      for (int k = 0; k < 9; k++) rhs = rhs * 255;
      forever begin
        if (y >= 255) break;
        lhs = 160'(y + 1);
        for (int k = 0; k < 8; k++) lhs = lhs * (y + 1);
        lhs = lhs << 50;
        if (lhs > rhs) break;
        y++;
      end
      gamma_rom[i] = 8'(y);
    end
  endfunction

  function void write_reg(logic [1:0] idx, logic [23:0] data);
    case (idx)
      htm_pkg::REG_EXPOSURE_GAIN: gain = data;
      htm_pkg::REG_BLACK_LEVEL:   black = data[7:0];
      htm_pkg::REG_WHITE_LEVEL:   white = data[7:0];
      default: ;
    endcase
  endfunction

  function logic [7:0] tone_code(logic [7:0] mant, logic [7:0] expo);
    int s;
    logic [63:0] lin, v, x, n, d, t;
    s = int'(expo) - htm_pkg::EXPO_BIAS + 16;
    if (s >= 0) begin
      if (mant == 0) lin = 0;
      else if (s > 40) lin = 64'hFFFF_FFFF;
      else begin
        lin = 64'(mant) << s;
        if (lin > 64'hFFFF_FFFF) lin = 64'hFFFF_FFFF;
      end
    end else if (-s >= 8) begin
      lin = 0;
    end else begin
      lin = 64'(mant) >> (-s);
    end
    v = (lin * gain) >> 16;
    if (v > 64'hFFFF_FFFF) v = 64'hFFFF_FFFF;
    x = (v * 39322) >> 16;
    if (x >= (64'd8 << 16)) begin
      t = 65536;
    end else begin
      n = x * (((64'd164495 * x) >> 16) + 1966);
      d = x * (((64'd159252 * x) >> 16) + 38666) + (64'd9175 << 16);
      t = (n << 16) / d;
      if (t > 65536) t = 65536;
    end
    return gamma_rom[t >> 6];
  endfunction

  function void note_pixel(logic [7:0] mr, logic [7:0] mg, logic [7:0] mb,
                           logic [7:0] expo, logic last);
    logic [31:0] ch [3];
    logic [31:0] luma, adj, span, lo, c;
    rgb_px_t px;
    ch[0] = tone_code(mr, expo);
    ch[1] = tone_code(mg, expo);
    ch[2] = tone_code(mb, expo);
    luma = 77 * ch[0] + 150 * ch[1] + 29 * ch[2];
    adj = 0;
    px = '0;
    if (white > black) begin
      span = white - black;
      lo = 32'(black) << 8;
      if (luma > lo) begin
        adj = (luma - lo) * 255 / span;
        if (adj > 65280) adj = 65280;
      end
      if (luma != 0) begin
        c = ch[0] * adj / luma; px.red   = (c > 255) ? 8'd255 : c[7:0];
        c = ch[1] * adj / luma; px.green = (c > 255) ? 8'd255 : c[7:0];
        c = ch[2] * adj / luma; px.blue  = (c > 255) ? 8'd255 : c[7:0];
      end
    end
    px.intensity_bin = luma[15:8];
    px.adjusted_bin  = adj[15:8];
    px.frame_end     = last;
    pending_px.push_back(px);
  endfunction

  function void check_pixel(rgb_px_t got);
    rgb_px_t want;
    if (pending_px.size() == 0) begin
      $display("%0t: unexpected pixel %h", $time, got);
      errors++;
      return;
    end
    want = pending_px.pop_front();
    if (got.red != want.red)
      $display("%0t: red exp %0d got %0d", $time, want.red, got.red);
    if (got.green != want.green)
      $display("%0t: green exp %0d got %0d", $time, want.green, got.green);
    if (got.blue != want.blue)
      $display("%0t: blue exp %0d got %0d", $time, want.blue, got.blue);
    if (got.intensity_bin != want.intensity_bin)
      $display("%0t: intensity_bin exp %0d got %0d", $time, want.intensity_bin,
               got.intensity_bin);
    if (got.adjusted_bin != want.adjusted_bin)
      $display("%0t: adjusted_bin exp %0d got %0d", $time, want.adjusted_bin,
               got.adjusted_bin);
    if (got.frame_end != want.frame_end)
      $display("%0t: frame_end exp %0d got %0d", $time, want.frame_end, got.frame_end);
    if (got != want) errors++;
  endfunction
endclass

module tb_hdr_rgbe_tone_map_pixel;

  localparam int STALL_LIMIT = 5000;  // idle cycles before the watchdog trips
  localparam int HOLD_CYCLES = 600;   // long output hold-off

  logic clk_i;
  logic rst_ni;

  htm_pix_in_if  pix_in ();
  htm_pix_out_if pix_out ();
  htm_cfg_if     cfg_bus ();

  hdr_rgbe_tone_map_pixel uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pix_i  (pix_in.sink),
    .pix_o  (pix_out.source),
    .cfg_i  (cfg_bus.sink)
  );

  tone_map_scoreboard sb = new();

  // traffic shaping knobs: percent of cycles, and a hold-off request
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  bit hold_request   = 0;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Output side ready: random stalls, plus a long hold-off on request,
  // counted here so the sender keeps pushing into a frozen pipeline.
  initial begin
    int hold_left;
    hold_left = 0;
    pix_out.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_left = HOLD_CYCLES;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        pix_out.ready <= 1'b0;
      end else begin
        pix_out.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Monitor: every accepted transaction updates the scoreboard.
  int quiet_cycles = 0;
  always @(posedge clk_i) begin
    bit moved;
    moved = 1'b0;
    if (rst_ni) begin
      if (cfg_bus.valid && cfg_bus.ready) begin
        sb.write_reg(cfg_bus.reg_index, cfg_bus.wdata);
        moved = 1'b1;
      end
      if (pix_in.valid && pix_in.ready) begin
        sb.note_pixel(pix_in.mantissa_red, pix_in.mantissa_green,
                      pix_in.mantissa_blue, pix_in.shared_exponent,
                      pix_in.last_pixel);
        moved = 1'b1;
      end
      if (pix_out.valid && pix_out.ready) begin
        sb.check_pixel({pix_out.red, pix_out.green, pix_out.blue,
                        pix_out.intensity_bin, pix_out.adjusted_bin,
                        pix_out.frame_end});
        moved = 1'b1;
      end
      quiet_cycles <= moved ? 0 : quiet_cycles + 1;
    end
  end

  // Watchdog: nothing moving for too long means the block hung.
  always @(posedge clk_i) begin
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Offer one pixel and hold it until accepted; idle afterwards at random.
  // valid is only lowered when a gap follows, never toggled within a step.
  task automatic send_pixel(logic [7:0] mr, logic [7:0] mg, logic [7:0] mb,
                            logic [7:0] expo, logic last);
    pix_in.valid           <= 1'b1;
    pix_in.mantissa_red    <= mr;
    pix_in.mantissa_green  <= mg;
    pix_in.mantissa_blue   <= mb;
    pix_in.shared_exponent <= expo;
    pix_in.last_pixel      <= last;
    do @(posedge clk_i); while (!pix_in.ready);
    if ($urandom_range(99) < send_idle_pct) begin
      pix_in.valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
  endtask

  task automatic send_random_pixel();
    logic [7:0] expo;
    logic [7:0] m [3];
    // mostly exponents around the bias, where the filmic curve is live
    expo = ($urandom_range(99) < 80) ? 8'($urandom_range(150, 112)) : 8'($urandom);
    foreach (m[k]) begin
      case ($urandom_range(9))
        0:       m[k] = 8'd0;
        1:       m[k] = 8'd255;
        default: m[k] = 8'($urandom);
      endcase
    end
    send_pixel(m[0], m[1], m[2], expo, ($urandom_range(15) == 0));
  endtask

  // Let the pipeline empty out before touching the registers.
  task automatic drain();
    pix_in.valid <= 1'b0;
    do @(posedge clk_i); while (sb.pending_px.size() != 0);
    repeat (htm_pkg::BACK_LAT + 10) @(posedge clk_i);
  endtask

  // valid drops after each write, keeping it to one update per step
  task automatic write_reg(logic [1:0] idx, logic [23:0] data);
    cfg_bus.valid     <= 1'b1;
    cfg_bus.reg_index <= idx;
    cfg_bus.wdata     <= data;
    do @(posedge clk_i); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    logic [23:0] gains [8];
    logic [7:0]  blacks [8];
    logic [7:0]  whites [8];

    pix_in.valid           = 1'b0;
    pix_in.mantissa_red    = '0;
    pix_in.mantissa_green  = '0;
    pix_in.mantissa_blue   = '0;
    pix_in.shared_exponent = '0;
    pix_in.last_pixel      = 1'b0;
    cfg_bus.valid          = 1'b0;
    cfg_bus.reg_index      = htm_pkg::REG_EXPOSURE_GAIN;
    cfg_bus.wdata          = '0;
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed pass at reset defaults: field extremes, exponent under- and
    // overflow, zero pixel, saturating curve, frame end both ways.
    send_pixel(8'd0,   8'd0,   8'd0,   8'd0,   1'b0);
    send_pixel(8'd255, 8'd255, 8'd255, 8'd255, 1'b1);
    send_pixel(8'd255, 8'd255, 8'd255, 8'd0,   1'b0);
    send_pixel(8'd128, 8'd64,  8'd32,  8'd136, 1'b0);
    send_pixel(8'd1,   8'd2,   8'd3,   8'd129, 1'b0);
    send_pixel(8'd255, 8'd0,   8'd0,   8'd128, 1'b1);
    send_pixel(8'd0,   8'd255, 8'd0,   8'd140, 1'b0);
    send_pixel(8'd0,   8'd0,   8'd255, 8'd150, 1'b0);
    send_pixel(8'd200, 8'd100, 8'd50,  8'd176, 1'b0);
    send_pixel(8'd170, 8'd85,  8'd170, 8'd177, 1'b0);
    send_pixel(8'd85,  8'd170, 8'd85,  8'd120, 1'b1);
    send_pixel(8'd255, 8'd255, 8'd255, 8'd135, 1'b0);
    drain();

    // Register settings per phase: extremes of gain, collapsed and inverted
    // levels, narrow span, and a stretched mid range.
    gains  = '{24'h010000, 24'h000000, 24'hFFFFFF, 24'h004000,
               24'h040000, 24'h000001, 24'h018000, 24'h010000};
    blacks = '{8'd0,   8'd255, 8'd40,  8'd100, 8'd200, 8'd0, 8'd16,  8'd128};
    whites = '{8'd255, 8'd255, 8'd220, 8'd100, 8'd50,  8'd1, 8'd235, 8'd129};

    for (int ph = 0; ph < 8; ph++) begin
      // upper bits on the 8-bit levels must be dropped
      write_reg(htm_pkg::REG_EXPOSURE_GAIN, gains[ph]);
      write_reg(htm_pkg::REG_BLACK_LEVEL, {16'hA5F0, blacks[ph]});
      write_reg(htm_pkg::REG_WHITE_LEVEL, {16'h5A0F, whites[ph]});
      write_reg(2'd3, 24'hFFFFFF);  // unmapped index, ignored

      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
        default: begin send_idle_pct = 27; recv_stall_pct = 27; end
      endcase

      for (int i = 0; i < 110; i++) begin
        if (ph == 2 && i == 20) hold_request = 1;
        if (ph == 5 && i == 50) begin
          // sender pauses until every pixel in flight has come back
          pix_in.valid <= 1'b0;
          do @(posedge clk_i); while (sb.pending_px.size() != 0);
        end
        send_random_pixel();
      end
      drain();
    end

    recv_stall_pct = 0;
    drain();
    if (sb.errors == 0 && sb.pending_px.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
